FILE: rtl/exterior_dangle_chain_min_assert.svh
// Assertion macros shared by the exterior loop dangle chain RTL.
`ifndef EXTERIOR_DANGLE_CHAIN_MIN_ASSERT_SVH
`define EXTERIOR_DANGLE_CHAIN_MIN_ASSERT_SVH

// same-cycle implication, checked outside reset
`define EDCM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define EDCM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/edcm_pkg.sv
// Types, constants and arithmetic helpers for the exterior loop dangle chain block.
package edcm_pkg;

    localparam int POS_FIELD_W = 16;
    localparam int EN_W        = 18;
    localparam int COST_W      = 32;
    localparam int SUM_W       = 34;
    localparam int JOIN_GAP    = 2;
    localparam int S_DATA_W    = 104;

    localparam logic signed [SUM_W-1:0]  COST_MAX_W = 34'sd2147483647;
    localparam logic signed [SUM_W-1:0]  COST_MIN_W = -34'sd2147483648;
    localparam logic signed [COST_W-1:0] COST_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COST_W-1:0] COST_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic [POS_FIELD_W-1:0] begin_pos;
        logic [POS_FIELD_W-1:0] end_pos;
        logic                   pk;
        logic signed [EN_W-1:0] e_none;
        logic signed [EN_W-1:0] e_left;
        logic signed [EN_W-1:0] e_right;
        logic signed [EN_W-1:0] e_both;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic signed [COST_W-1:0] total;
        logic signed [COST_W-1:0] free_cost;
        logic signed [COST_W-1:0] taken_cost;
        logic                     error;
    } sum_t;

    function automatic logic signed [COST_W-1:0] sat_cost(input logic signed [SUM_W-1:0] v);
        logic signed [COST_W-1:0] r;
        if (v > COST_MAX_W)
        begin
            r = COST_MAX;
        end
        else if (v < COST_MIN_W)
        begin
            r = COST_MIN;
        end
        else
        begin
            r = $signed(v[COST_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] min_wide(input logic signed [SUM_W-1:0] a,
                                                         input logic signed [SUM_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [COST_W-1:0] min_cost(input logic signed [COST_W-1:0] a,
                                                          input logic signed [COST_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

FILE: rtl/edcm_chain.sv
// Chain state registers and the per-child two-state min-plus update.
`include "exterior_dangle_chain_min_assert.svh"

module edcm_chain #(
    parameter int INF_VALUE = 10000000,
    parameter int POS_WIDTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step,
    input  edcm_pkg::item_t item,
    output edcm_pkg::sum_t  sum
);

    localparam int DW = POS_WIDTH + 1;
    localparam logic signed [edcm_pkg::COST_W-1:0] INF_COST = edcm_pkg::COST_W'(INF_VALUE);
    localparam logic signed [edcm_pkg::SUM_W-1:0]  INF_WIDE = edcm_pkg::SUM_W'(INF_VALUE);

    logic signed [edcm_pkg::COST_W-1:0] free_reg, free_next;
    logic signed [edcm_pkg::COST_W-1:0] taken_reg, taken_next;
    logic signed [edcm_pkg::COST_W-1:0] total_reg, total_next;
    logic [POS_WIDTH-1:0]               prev_end_reg, prev_end_next;
    logic                               seen_reg, seen_next;
    logic                               error_reg, error_next;

    logic [POS_WIDTH-1:0]               b_pos;
    logic [DW-1:0]                      gap;
    logic                               joins;
    logic                               active;
    logic                               close;
    logic signed [edcm_pkg::COST_W-1:0] chain_min;
    logic signed [edcm_pkg::COST_W-1:0] total_closed;
    logic signed [edcm_pkg::COST_W-1:0] f_use, t_use, total_use;
    logic signed [edcm_pkg::SUM_W-1:0]  f_w, t_w;
    logic signed [edcm_pkg::SUM_W-1:0]  nf, nt;
    logic signed [edcm_pkg::COST_W-1:0] free_upd, taken_upd, total_upd;
    logic                               error_upd;

    always_comb
    begin
        b_pos        = POS_WIDTH'(item.begin_pos);
        gap          = {1'b0, b_pos} - {1'b0, prev_end_reg};
        joins        = !gap[POS_WIDTH] && (gap <= DW'(edcm_pkg::JOIN_GAP));
        active       = !seen_reg || !item.pk;
        close        = seen_reg && !joins;
        chain_min    = edcm_pkg::min_cost(free_reg, taken_reg);
        total_closed = edcm_pkg::sat_cost(edcm_pkg::SUM_W'(total_reg)
                                          + edcm_pkg::SUM_W'(chain_min));
        f_use        = close ? '0 : free_reg;
        t_use        = close ? INF_COST : taken_reg;
        total_use    = close ? total_closed : total_reg;
        f_w          = edcm_pkg::SUM_W'(f_use);
        t_w          = edcm_pkg::SUM_W'(t_use);
        nf = edcm_pkg::min_wide(edcm_pkg::min_wide(f_w + edcm_pkg::SUM_W'(item.e_none),
                                                   f_w + edcm_pkg::SUM_W'(item.e_left)),
                                t_w + edcm_pkg::SUM_W'(item.e_none));
        nt = edcm_pkg::min_wide(edcm_pkg::min_wide(f_w + edcm_pkg::SUM_W'(item.e_right),
                                                   t_w + edcm_pkg::SUM_W'(item.e_right)),
                                f_w + edcm_pkg::SUM_W'(item.e_both));
        if (active)
        begin
            free_upd  = edcm_pkg::sat_cost(nf);
            taken_upd = edcm_pkg::sat_cost(nt);
            total_upd = total_use;
            error_upd = error_reg || (nf > INF_WIDE) || (nt > INF_WIDE);
        end
        else
        begin
            free_upd  = free_reg;
            taken_upd = taken_reg;
            total_upd = total_reg;
            error_upd = error_reg;
        end
        sum.total      = total_upd;
        sum.free_cost  = free_upd;
        sum.taken_cost = taken_upd;
        sum.error      = error_upd;
    end

    always_comb
    begin
        free_next     = free_reg;
        taken_next    = taken_reg;
        total_next    = total_reg;
        prev_end_next = prev_end_reg;
        seen_next     = seen_reg;
        error_next    = error_reg;
        if (step)
        begin
            if (item.last)
            begin
                free_next     = '0;
                taken_next    = INF_COST;
                total_next    = '0;
                prev_end_next = '0;
                seen_next     = 1'b0;
                error_next    = 1'b0;
            end
            else
            begin
                free_next     = free_upd;
                taken_next    = taken_upd;
                total_next    = total_upd;
                prev_end_next = POS_WIDTH'(item.end_pos);
                seen_next     = 1'b1;
                error_next    = error_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg     <= '0;
            taken_reg    <= INF_COST;
            total_reg    <= '0;
            prev_end_reg <= '0;
            seen_reg     <= 1'b0;
            error_reg    <= 1'b0;
        end
        else
        begin
            free_reg     <= free_next;
            taken_reg    <= taken_next;
            total_reg    <= total_next;
            prev_end_reg <= prev_end_next;
            seen_reg     <= seen_next;
            error_reg    <= error_next;
        end
    end

    `EDCM_ASSERT_NEXT(a_last_clears, clk, rst_n, step && item.last,
        !seen_reg && !error_reg && (free_reg == '0) && (taken_reg == INF_COST)
        && (total_reg == '0), "chain state not cleared after last child")
    `EDCM_ASSERT_NEXT(a_seen_sets, clk, rst_n, step && !item.last, seen_reg,
        "first child not recorded")
    `EDCM_ASSERT_NEXT(a_error_sticky, clk, rst_n, error_reg && !(step && item.last),
        error_reg, "overflow flag dropped inside a loop")
    `EDCM_ASSERT_NEXT(a_idle_holds, clk, rst_n, !step,
        $stable(free_reg) && $stable(taken_reg) && $stable(total_reg),
        "chain state moved without a child")

endmodule

FILE: rtl/exterior_dangle_chain_min.sv
// Top level of the exterior loop dangle chain block: stream ports and pipeline stages.
//
// Usage:
//   Feed the stem children of one exterior loop in order on the s_* channel,
//   one word per child; s_tlast marks the final child of the loop and
//   s_tuser flags a pseudoknot child.
//   One result word per loop leaves on the m_* channel: the summed chain
//   minimum energy in m_tdata and the overflow flag in m_tuser.
//   A loop's result moves from the input register, through the chain update,
//   into the close stage, and from the final chain close into the output
//   register.
//   Throughput: one child per cycle while s_tready is high; the chain state
//   loop closes through the add/min/saturate logic of the update stage.
//   Reset clears the chain state to an empty loop and empties every stage.
//   When the receiver stalls, a finished result holds in the output register
//   and a second one in the close stage; children that carry no result keep
//   flowing until a further last child would need a full stage, at which
//   point s_tready drops.
`include "exterior_dangle_chain_min_assert.svh"

module exterior_dangle_chain_min #(
    parameter int INF_VALUE = 10000000,
    parameter int POS_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // child_begin, child_end, energy_none, energy_left, energy_right, energy_both
    input  logic [edcm_pkg::S_DATA_W-1:0] s_tdata,
    // is_pseudoknot
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // total_energy
    output logic [edcm_pkg::COST_W-1:0]   m_tdata,
    // overflow
    output logic                          m_tuser
);

    logic                               in_valid_reg;
    edcm_pkg::item_t                    in_item_reg;
    logic                               fin_valid_reg;
    edcm_pkg::sum_t                     fin_reg;
    logic                               out_valid_reg;
    logic signed [edcm_pkg::COST_W-1:0] out_total_reg;
    logic                               out_ovf_reg;

    edcm_pkg::item_t                    s_item;
    edcm_pkg::sum_t                     sum;
    logic                               out_ready;
    logic                               fin_ready;
    logic                               in_move;
    logic                               step;
    logic                               s_take;
    logic signed [edcm_pkg::COST_W-1:0] fin_min;
    logic signed [edcm_pkg::COST_W-1:0] fin_total;

    always_comb
    begin
        s_item.begin_pos = s_tdata[15:0];
        s_item.end_pos   = s_tdata[31:16];
        s_item.pk        = s_tuser;
        s_item.e_none    = $signed(s_tdata[49:32]);
        s_item.e_left    = $signed(s_tdata[67:50]);
        s_item.e_right   = $signed(s_tdata[85:68]);
        s_item.e_both    = $signed(s_tdata[103:86]);
        s_item.last      = s_tlast;
    end

    assign out_ready = !out_valid_reg || m_tready;
    assign fin_ready = !fin_valid_reg || out_ready;
    assign in_move   = !in_item_reg.last || fin_ready;
    assign step      = in_valid_reg && in_move;
    assign s_tready  = !in_valid_reg || in_move;
    assign s_take    = s_tvalid && s_tready;

    assign fin_min   = edcm_pkg::min_cost(fin_reg.free_cost, fin_reg.taken_cost);
    assign fin_total = edcm_pkg::sat_cost(edcm_pkg::SUM_W'(fin_reg.total)
                                          + edcm_pkg::SUM_W'(fin_min));

    edcm_chain #(
        .INF_VALUE(INF_VALUE),
        .POS_WIDTH(POS_WIDTH)
    ) u_chain (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .item (in_item_reg),
        .sum  (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fin_ready)
            begin
                fin_valid_reg <= step && in_item_reg.last;
            end
            if (out_ready)
            begin
                out_valid_reg <= fin_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_item_reg <= s_item;
        end
        if (fin_ready && step && in_item_reg.last)
        begin
            fin_reg <= sum;
        end
        if (out_ready && fin_valid_reg)
        begin
            out_total_reg <= fin_total;
            out_ovf_reg   <= fin_reg.error;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_total_reg;
    assign m_tuser  = out_ovf_reg;

    `EDCM_ASSERT_NOW(a_stall_has_word, clk, rst_n, !s_tready,
        in_valid_reg && in_item_reg.last && fin_valid_reg && out_valid_reg,
        "input stalled without a full pipeline")
    `EDCM_ASSERT_NEXT(a_fin_holds, clk, rst_n, fin_valid_reg && !out_ready,
        fin_valid_reg && $stable(fin_reg), "close stage lost its word")
    `EDCM_ASSERT_NEXT(a_last_reaches_fin, clk, rst_n, step && in_item_reg.last,
        fin_valid_reg, "last child did not reach close stage")

endmodule

FILE: tb/sv/testbench.sv
// Testbench for exterior_dangle_chain_min: directed and random child streams, scoreboard check.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COST_LIMIT = 10000000;
    localparam int TARGET_CHILDREN = 1450;
    localparam int FLAT_CHAIN_LEN = 100;

    typedef struct {
        logic [edcm_pkg::COST_W-1:0] total;
        logic                        ovf;
    } loop_result_t;

    class loop_energy_model;
        longint         free_cost;
        longint         taken_cost;
        longint         total;
        logic [15:0]    prev_end;
        bit             started;
        bit             overflowed;
        loop_result_t   pending_totals[$];
        int             errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            free_cost = 0;
            taken_cost = COST_LIMIT;
            total = 0;
            prev_end = '0;
            started = 0;
            overflowed = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void close_chain();
            longint m;
            m = (free_cost < taken_cost) ? free_cost : taken_cost;
            total = clamp32(total + m);
            free_cost = 0;
            taken_cost = COST_LIMIT;
        endfunction

        function void take_child(edcm_pkg::item_t c);
            longint en, el, er, eb, nf, nt, gap;
            loop_result_t r;
            if (!started || !c.pk)
            begin
                en = longint'(c.e_none);
                el = longint'(c.e_left);
                er = longint'(c.e_right);
                eb = longint'(c.e_both);
                if (started)
                begin
                    gap = longint'(c.begin_pos) - longint'(prev_end);
                    if (gap < 0 || gap > edcm_pkg::JOIN_GAP)
                        close_chain();
                end
                nf = free_cost + en;
                if (free_cost + el < nf)
                    nf = free_cost + el;
                if (taken_cost + en < nf)
                    nf = taken_cost + en;
                nt = free_cost + er;
                if (taken_cost + er < nt)
                    nt = taken_cost + er;
                if (free_cost + eb < nt)
                    nt = free_cost + eb;
                if (nf > COST_LIMIT || nt > COST_LIMIT)
                    overflowed = 1;
                free_cost = clamp32(nf);
                taken_cost = clamp32(nt);
            end
            started = 1;
            prev_end = c.end_pos;
            if (c.last)
            begin
                close_chain();
                r.total = total[edcm_pkg::COST_W-1:0];
                r.ovf = overflowed;
                pending_totals = {pending_totals, r};
                clear();
            end
        endfunction

        function void check_total(logic [edcm_pkg::COST_W-1:0] got_total, logic got_ovf);
            loop_result_t r;
            if (pending_totals.size() == 0)
            begin
                $error("result word with no loop pending: total_energy %0d overflow %0b",
                       $signed(got_total), got_ovf);
                errors++;
                return;
            end
            r = pending_totals.pop_front();
            if (got_total !== r.total)
            begin
                $error("total_energy: expected %0d, actual %0d",
                       $signed(r.total), $signed(got_total));
                errors++;
            end
            if (got_ovf !== r.ovf)
            begin
                $error("overflow: expected %0b, actual %0b", r.ovf, got_ovf);
                errors++;
            end
        endfunction

        function int pending();
            return pending_totals.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [edcm_pkg::S_DATA_W-1:0] s_tdata;
    logic                          s_tuser;
    logic                          s_tlast;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [edcm_pkg::COST_W-1:0]   m_tdata;
    logic                          m_tuser;

    edcm_pkg::item_t  cur_child;
    int               idle_pct;
    int               children_sent;
    loop_energy_model book = new();

    exterior_dangle_chain_min #(
        .INF_VALUE(COST_LIMIT),
        .POS_WIDTH(16)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("exterior_dangle_chain_min verification failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && s_tvalid && s_tready)
            book.take_child(cur_child);
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            book.check_total(m_tdata, m_tuser);
    end

    // stall the result side in short bursts while idling is on
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic edcm_pkg::item_t mk_child(int b, int e, bit pk, int en, int el, int er,
                                                 int eb, bit last);
        edcm_pkg::item_t c;
        c.begin_pos = 16'(b);
        c.end_pos = 16'(e);
        c.pk = pk;
        c.e_none = 18'(en);
        c.e_left = 18'(el);
        c.e_right = 18'(er);
        c.e_both = 18'(eb);
        c.last = last;
        return c;
    endfunction

    function automatic logic signed [edcm_pkg::EN_W-1:0] rand_energy(bit hot);
        if (hot)
            return 18'($urandom_range(100000, 131071));
        if ($urandom_range(0, 3) == 0)
            return 18'($urandom);
        return 18'(int'($urandom_range(0, 6000)) - 3000);
    endfunction

    task automatic send_child(input edcm_pkg::item_t c);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {c.e_both, c.e_right, c.e_left, c.e_none, c.end_pos, c.begin_pos};
        s_tuser   <= c.pk;
        s_tlast   <= c.last;
        cur_child <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        children_sent++;
    endtask

    task automatic send_loop(input int len, input bit hot);
        edcm_pkg::item_t c;
        logic [15:0]     last_end;
        int              pick;
        last_end = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 99);
            if (hot || pick < 60)
                c.begin_pos = last_end + 16'($urandom_range(0, 2));
            else if (pick < 75)
                c.begin_pos = last_end - 16'($urandom_range(1, 50));
            else
                c.begin_pos = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
                c.end_pos = 16'($urandom);
            else
                c.end_pos = c.begin_pos + 16'($urandom_range(0, 300));
            c.pk = hot ? ($urandom_range(0, 99) < 3) : ($urandom_range(0, 99) < 12);
            c.e_none = rand_energy(hot);
            c.e_left = rand_energy(hot);
            c.e_right = rand_energy(hot);
            c.e_both = rand_energy(hot);
            c.last = (i == len - 1);
            send_child(c);
            last_end = c.end_pos;
        end
    endtask

    // one long chain that drives the states past INF for a positive energy, closed by a lone child
    task automatic send_flat_chain(input int energy);
        for (int i = 0; i < FLAT_CHAIN_LEN; i++)
            send_child(mk_child(1000, 1000, 1'b0, energy, energy, energy, energy, 1'b0));
        send_child(mk_child(5000, 5010, 1'b0, energy, energy, energy, energy, 1'b1));
    endtask

    initial
    begin
        int len;
        int mode;
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= 1'b0;
        s_tlast       <= 1'b0;
        cur_child     <= '0;
        idle_pct      = 0;
        children_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-child loops at the field extremes, the second a pseudoknot as the first child of its loop
        send_child(mk_child(0, 65535, 1'b0, 131071, 131071, 131071, 131071, 1'b1));
        send_child(mk_child(65535, 0, 1'b1, -131072, -131072, -131072, -131072, 1'b1));
        // join at gap 0 and 2, break at 3, start before previous end, skipped pseudoknots
        send_child(mk_child(10, 20, 1'b0, -300, -250, -400, -500, 1'b0));
        send_child(mk_child(20, 30, 1'b0, 100, -50, -20, 200, 1'b0));
        send_child(mk_child(32, 40, 1'b0, -10, -600, 30, -700, 1'b0));
        send_child(mk_child(43, 50, 1'b0, 5, -5, -15, 0, 1'b0));
        send_child(mk_child(45, 60, 1'b0, -1000, 0, 0, 0, 1'b0));
        send_child(mk_child(61, 300, 1'b1, -90000, -90000, -90000, -90000, 1'b0));
        send_child(mk_child(302, 310, 1'b0, -7, -8, -9, -10, 1'b0));
        send_child(mk_child(312, 400, 1'b1, -5000, -5000, -5000, -5000, 1'b1));
        // positions at the top of the range and a wrap back to the bottom of the range
        send_child(mk_child(65534, 65535, 1'b0, 700, -700, 300, -300, 1'b0));
        send_child(mk_child(65535, 65535, 1'b0, -131072, 131071, 0, -1, 1'b0));
        send_child(mk_child(1, 3, 1'b0, 2000, 1999, -2000, 0, 1'b0));
        send_child(mk_child(3, 4, 1'b0, 1, 2, 3, 4, 1'b1));
        send_child(mk_child(7, 9, 1'b1, -20, -30, -40, -50, 1'b0));
        send_child(mk_child(10, 11, 1'b1, -60, -70, -80, -90, 1'b1));

        send_flat_chain(131071);
        send_flat_chain(-131072);

        idle_pct = 25;
        while (children_sent < TARGET_CHILDREN)
        begin
            if (children_sent > TARGET_CHILDREN - 250)
                idle_pct = 0;
            else if ($urandom_range(0, 14) == 0)
            begin
                mode = $urandom_range(0, 2);
                idle_pct = (mode == 0) ? 0 : ((mode == 1) ? 25 : 60);
            end
            if ($urandom_range(0, 99) < 2)
                send_loop(125, 1'b1);
            else
            begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
                send_loop(len, 1'b0);
            end
        end
        s_tvalid <= 1'b0;

        while (book.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (book.errors == 0)
            $display("exterior_dangle_chain_min verification clean");
        else
            $display("exterior_dangle_chain_min verification failed");
        $finish;
    end

endmodule
